### sv/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define STDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define STDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/stdc_pkg.sv
package stdc_pkg;

  // Line scanning phase, one-hot.
  typedef enum logic [2:0] {
    PHASE_LEAD = 3'b001,
    PHASE_WORD = 3'b010,
    PHASE_REST = 3'b100
  } phase_t;

  // Verdict on the first word of a line.
  typedef enum logic [1:0] {
    KW_NONE  = 2'b00,
    KW_OPEN  = 2'b01,
    KW_CLOSE = 2'b10
  } kw_kind_t;

  localparam int WORD_CAP = 10;

  // First word of a line, byte 0 in the lowest bits.
  typedef logic [WORD_CAP-1:0][7:0] stdc_chars_t;

  // What one indentation cell tells its neighbour and the row.
  typedef struct packed {
    logic keep;
    logic hit;
    logic boundary;
  } stdc_cell_stat_t;

  localparam int KW_NUM = 12;

  // Keywords as strings, first letter in the highest used byte.
  localparam logic [8*WORD_CAP-1:0] KW_TEXT [KW_NUM] = '{
    "end", "endif", "enddo", "endselect", "if", "for", "while", "do",
    "select", "function", "program", "subroutine"
  };
  localparam int KW_LEN [KW_NUM] = '{3, 5, 5, 9, 2, 3, 5, 2, 6, 8, 7, 10};
  localparam logic KW_IS_OPEN [KW_NUM] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

endpackage

### sv/stdc_indent_cell.sv
// One entry of the indentation stack, with its compare against the current width.
module stdc_indent_cell (
  input  logic                      clk,
  input  logic                      we,
  input  logic [15:0]               lw,
  input  logic                      in_use,
  input  logic                      keep_left,
  output stdc_pkg::stdc_cell_stat_t stat
);

  logic [15:0] level;

  always_ff @(posedge clk) begin
    if (we) begin
      level <= lw;
    end
  end

  // An entry survives the pop when it is held and not wider than the line.
  assign stat.keep     = in_use && (level <= lw);
  assign stat.hit      = stat.keep && (level == lw);
  assign stat.boundary = keep_left && !stat.keep;

endmodule

### sv/stdc_indent_stack.sv
// Row of indentation cells with the fill count; pops and pushes in the same update.
module stdc_indent_stack #(
  parameter int DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         upd,
  input  logic                         clr,
  input  logic [15:0]                  lw,
  output logic [$clog2(DEPTH+1)-1:0]   count_after,
  output logic                         drop
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          new_count;
  logic                      any_hit;
  logic                      push;
  logic                      full;
  logic                      keep_left [DEPTH];
  logic                      in_use    [DEPTH];
  logic                      we        [DEPTH];
  stdc_pkg::stdc_cell_stat_t stat      [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign keep_left[i] = 1'b1;
    end else begin : g_rest
      assign keep_left[i] = stat[i-1].keep;
    end
    assign in_use[i] = count > CNT_W'(i);
    assign we[i]     = upd && push && stat[i].boundary;

    stdc_indent_cell u_cell (
      .clk       (clk),
      .we        (we[i]),
      .lw        (lw),
      .in_use    (in_use[i]),
      .keep_left (keep_left[i]),
      .stat      (stat[i])
    );
  end

  always_comb begin
    any_hit   = 1'b0;
    new_count = '0;
    for (int i = 0; i < DEPTH; i++) begin
      any_hit = any_hit | stat[i].hit;
      if (stat[i].boundary) begin
        new_count = new_count | CNT_W'(i);
      end
    end
    full = stat[DEPTH-1].keep;
    if (full) begin
      new_count = CNT_W'(DEPTH);
    end
    // The kept top is never wider than the line, so a push is due unless it is equal or the line width is zero.
    push = (lw != 16'd0) && !any_hit;
  end

  assign count_after = upd ? (new_count + CNT_W'(push && !full)) : count;
  assign drop        = upd && push && full;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      count <= '0;
    end else if (upd) begin
      count <= count_after;
    end
  end

endmodule

### sv/stdc_word_match.sv
// Compares the first word of a line against the block keywords.
module stdc_word_match (
  input  stdc_pkg::stdc_chars_t chars,
  input  logic [3:0]            len,
  output stdc_pkg::kw_kind_t    kind
);

  logic [stdc_pkg::KW_NUM-1:0] match;
  logic                        open_hit;
  logic                        close_hit;

  always_comb begin
    open_hit  = 1'b0;
    close_hit = 1'b0;
    for (int k = 0; k < stdc_pkg::KW_NUM; k++) begin
      match[k] = (len == 4'(stdc_pkg::KW_LEN[k]));
      for (int j = 0; j < stdc_pkg::KW_LEN[k]; j++) begin
        match[k] = match[k] &&
          (chars[j] == stdc_pkg::KW_TEXT[k][8*(stdc_pkg::KW_LEN[k]-1-j) +: 8]);
      end
      if (match[k] && stdc_pkg::KW_IS_OPEN[k]) begin
        open_hit = 1'b1;
      end
      if (match[k] && !stdc_pkg::KW_IS_OPEN[k]) begin
        close_hit = 1'b1;
      end
    end
    if (open_hit) begin
      kind = stdc_pkg::KW_OPEN;
    end else if (close_hit) begin
      kind = stdc_pkg::KW_CLOSE;
    end else begin
      kind = stdc_pkg::KW_NONE;
    end
  end

endmodule

### sv/source_token_depth_scanner.sv
// Channel   Direction  Beat carries
// s_*       in         one source byte, tlast on the final byte
// m_*       out        token count, deepest level, indentation overflow flag
// APB       in/out     register 0: indent_mode
//
// The whole update of a source byte, the pop and push of the indentation stack
// included, settles combinationally across the row of cells as the byte is taken.
// A result leaves the cycle after the last byte is taken and sits in the output
// register until taken. Any byte waits while that register is full and not taken.
// Reset is synchronous and active high; it clears all control state and sets
// indent_mode to zero. The scan state clears itself after each result.
module source_token_depth_scanner #(
  parameter int INDENT_STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Source stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_byte
  input  logic        s_tlast,   // last
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [23:0] token_count, [39:24] max_depth,
                                 // [40] indent_overflow, [47:41] zero
);

  localparam int CNT_W = $clog2(INDENT_STACK_DEPTH + 1);

  localparam logic        CFG_IDX_INDENT_MODE = 1'b0;
  localparam logic [23:0] TOKEN_MAX           = 24'hFF_FFFF;
  localparam logic [15:0] LEVEL_MAX           = 16'hFFFF;
  localparam logic [16:0] TAB_WIDTH           = 17'd8;
  localparam logic [7:0]  CH_LF               = 8'h0A;
  localparam logic [7:0]  CH_TAB              = 8'h09;
  localparam logic [7:0]  CH_CASE             = 8'h20;

  // Configuration.
  logic indent_mode;

  // Scan state.
  logic                  inside_word;
  logic [15:0]           bracket_level;
  logic [23:0]           token_total;
  logic [15:0]           deepest;
  logic [15:0]           keyword_level;
  stdc_pkg::phase_t      line_phase;
  logic [15:0]           leading_width;
  stdc_pkg::stdc_chars_t first_word_chars;
  logic [3:0]            first_word_length;
  logic                  overflow_seen;

  // Per-byte next values.
  logic                  fire;
  logic                  is_alpha;
  logic                  is_word;
  logic                  is_space;
  logic [23:0]           token_next;
  logic [15:0]           bracket_next;
  logic [15:0]           keyword_next;
  logic [15:0]           deepest_next;
  logic                  overflow_next;
  stdc_pkg::phase_t      phase_next;
  logic [15:0]           leading_next;
  logic [16:0]           leading_sum;
  logic [3:0]            length_upd;
  logic [3:0]            length_next;
  stdc_pkg::stdc_chars_t chars_upd;
  logic                  word_step;
  logic                  append;
  logic                  judge_mid;
  logic                  judge;
  logic                  indent_go;
  stdc_pkg::kw_kind_t    kw_kind;
  logic [CNT_W-1:0]      count_after;
  logic                  stack_drop;
  logic [15:0]           peak_a;
  logic [15:0]           peak_b;
  logic [15:0]           peak_c;

  // Result register.
  logic [23:0]           res_tokens;
  logic [15:0]           res_depth;
  logic                  res_overflow;

  // Configuration port: no wait states, word addressed.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_INDENT_MODE) ? {31'b0, indent_mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      indent_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == CFG_IDX_INDENT_MODE)) begin
      indent_mode <= pwdata[0];
    end
  end

  // A byte can come in unless the output register is full and not taken.
  // The check is made for every byte so that ready does not look at tlast.
  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;

  assign is_alpha = ((s_tdata >= "a") && (s_tdata <= "z")) ||
                    ((s_tdata >= "A") && (s_tdata <= "Z"));
  assign is_word  = is_alpha || ((s_tdata >= "0") && (s_tdata <= "9")) ||
                    (s_tdata == "_");
  assign is_space = (s_tdata == " ") || ((s_tdata >= 8'd9) && (s_tdata <= 8'd13));

  // Tokens and brackets.
  always_comb begin
    token_next = token_total;
    if (((is_word && !inside_word) || (!is_word && !is_space)) &&
        (token_total != TOKEN_MAX)) begin
      token_next = token_total + 24'd1;
    end

    bracket_next = bracket_level;
    if ((s_tdata == "(") || (s_tdata == "[") || (s_tdata == "{")) begin
      if (bracket_level != LEVEL_MAX) begin
        bracket_next = bracket_level + 16'd1;
      end
    end else if (((s_tdata == ")") || (s_tdata == "]") || (s_tdata == "}")) &&
                 (bracket_level != 16'd0)) begin
      bracket_next = bracket_level - 16'd1;
    end
  end

  // Line phase, leading width and the gathering of the first word.
  always_comb begin
    phase_next  = line_phase;
    leading_sum = {1'b0, leading_width} + ((s_tdata == CH_TAB) ? TAB_WIDTH : 17'd1);
    leading_next = leading_width;
    word_step   = 1'b0;
    judge_mid   = 1'b0;
    indent_go   = 1'b0;
    append      = 1'b0;

    if (s_tdata == CH_LF) begin
      judge_mid    = (line_phase == stdc_pkg::PHASE_WORD);
      phase_next   = stdc_pkg::PHASE_LEAD;
      leading_next = 16'd0;
    end else if (line_phase == stdc_pkg::PHASE_LEAD) begin
      if ((s_tdata == " ") || (s_tdata == CH_TAB)) begin
        leading_next = leading_sum[16] ? LEVEL_MAX : leading_sum[15:0];
      end else if ((s_tdata == "#") || (s_tdata == "%") || (s_tdata == "!")) begin
        // Preprocessor, comment and directive lines are skipped.
        phase_next = stdc_pkg::PHASE_REST;
      end else if (indent_mode) begin
        indent_go  = 1'b1;
        phase_next = stdc_pkg::PHASE_REST;
      end else begin
        phase_next = stdc_pkg::PHASE_WORD;
        word_step  = 1'b1;
      end
    end else if (line_phase == stdc_pkg::PHASE_WORD) begin
      word_step = 1'b1;
    end

    if (word_step) begin
      if (is_alpha) begin
        append = 1'b1;
      end else begin
        judge_mid  = 1'b1;
        phase_next = stdc_pkg::PHASE_REST;
      end
    end

    chars_upd  = first_word_chars;
    length_upd = first_word_length;
    if (append) begin
      if (first_word_length < 4'(stdc_pkg::WORD_CAP)) begin
        chars_upd[first_word_length] = s_tdata | CH_CASE;
      end
      // The length climbs one past the cap so that a long word matches nothing.
      if (first_word_length <= 4'(stdc_pkg::WORD_CAP)) begin
        length_upd = first_word_length + 4'd1;
      end
    end
    length_next = (s_tdata == CH_LF) ? 4'd0 : length_upd;

    // A word still open at the final byte is judged before the result goes out.
    judge = judge_mid || (s_tlast && (phase_next == stdc_pkg::PHASE_WORD));
  end

  stdc_word_match u_match (
    .chars (chars_upd),
    .len   (length_upd),
    .kind  (kw_kind)
  );

  always_comb begin
    keyword_next = keyword_level;
    if (judge) begin
      unique case (kw_kind)
        stdc_pkg::KW_OPEN: begin
          if (keyword_level != LEVEL_MAX) begin
            keyword_next = keyword_level + 16'd1;
          end
        end
        stdc_pkg::KW_CLOSE: begin
          if (keyword_level != 16'd0) begin
            keyword_next = keyword_level - 16'd1;
          end
        end
        default: begin
          keyword_next = keyword_level;
        end
      endcase
    end
  end

  stdc_indent_stack #(
    .DEPTH (INDENT_STACK_DEPTH)
  ) u_stack (
    .clk         (clk),
    .rst         (rst),
    .upd         (fire && indent_go),
    .clr         (fire && s_tlast),
    .lw          (leading_width),
    .count_after (count_after),
    .drop        (stack_drop)
  );

  // Every level only ever rises through a step that also raised the deepest
  // value, so taking the maximum over all of them each beat is exact.
  always_comb begin
    peak_a        = (bracket_next > deepest) ? bracket_next : deepest;
    peak_b        = (keyword_next > peak_a) ? keyword_next : peak_a;
    peak_c        = 16'(count_after);
    deepest_next  = (peak_c > peak_b) ? peak_c : peak_b;
    overflow_next = overflow_seen || stack_drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid          <= 1'b0;
      inside_word       <= 1'b0;
      bracket_level     <= 16'd0;
      token_total       <= 24'd0;
      deepest           <= 16'd0;
      keyword_level     <= 16'd0;
      line_phase        <= stdc_pkg::PHASE_LEAD;
      leading_width     <= 16'd0;
      first_word_length <= 4'd0;
      overflow_seen     <= 1'b0;
    end else begin
      // A new result may replace one that is taken in the same cycle.
      if (fire && s_tlast) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fire) begin
        if (s_tlast) begin
          inside_word       <= 1'b0;
          bracket_level     <= 16'd0;
          token_total       <= 24'd0;
          deepest           <= 16'd0;
          keyword_level     <= 16'd0;
          line_phase        <= stdc_pkg::PHASE_LEAD;
          leading_width     <= 16'd0;
          first_word_length <= 4'd0;
          overflow_seen     <= 1'b0;
        end else begin
          inside_word       <= is_word;
          bracket_level     <= bracket_next;
          token_total       <= token_next;
          deepest           <= deepest_next;
          keyword_level     <= keyword_next;
          line_phase        <= phase_next;
          leading_width     <= leading_next;
          first_word_length <= length_next;
          overflow_seen     <= overflow_next;
        end
      end
    end
  end

  // Payload registers: the word store and the result.
  always_ff @(posedge clk) begin
    if (fire) begin
      first_word_chars <= chars_upd;
    end
    if (fire && s_tlast) begin
      res_tokens   <= token_next;
      res_depth    <= deepest_next;
      res_overflow <= overflow_next;
    end
  end

  assign m_tdata = {7'b0, res_overflow, res_depth, res_tokens};

endmodule

### sv/stdc_checker.sv
`include "assert_macros.svh"

// Port-level checks on the scanner.
module stdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `STDC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  `STDC_ASSERT(a_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

  `STDC_ASSERT(a_last_gives_result, clk, rst, (s_tvalid && s_tready && s_tlast) |=> m_tvalid, "no result after last beat")

  `STDC_ASSERT(a_result_from_last, clk, rst, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast), "result without last beat")

  `STDC_ASSERT(a_stall_blocks_input, clk, rst, (m_tvalid && !m_tready) |-> !s_tready, "input taken while result stalled")

endmodule

bind source_token_depth_scanner stdc_checker u_stdc_checker (.*);

### tb/source_token_depth_scanner_test.sv
module source_token_depth_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = 32;
  localparam int TAB_COLUMNS = 8;
  localparam logic [2:0] ADDR_INDENT_MODE = 3'd0;
  localparam bit MODE_KEYWORD = 1'b0;
  localparam bit MODE_INDENT = 1'b1;
  // A result leaves in the cycle after the last byte; spare cycles cover any
  // work still in flight before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 700;
  localparam int RANDOM_SOURCES = 20;
  localparam int CALM_BYTES = 150;
  localparam bit [23:0] TOKEN_CEIL = 24'hFFFFFF;
  localparam bit [15:0] LEVEL_CEIL = 16'hFFFF;
  localparam int CLOSER_COUNT = 4;

  typedef struct packed {
    bit [23:0] tokens;
    bit [15:0] depth;
    bit        overflow;
  } scan_result_t;

  typedef enum bit {ROW_BYTE, ROW_MODE} row_kind_e;

  // One row of the directed table: either a source byte or a mode write. Rows
  // flagged as typed carry the result that their source must give.
  typedef struct packed {
    row_kind_e    kind;
    bit [7:0]     data;
    bit           last;
    bit           typed;
    scan_result_t want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [28] = '{
    // Single bytes straight after reset: a letter, the lowest and highest byte
    // values, an opening bracket and a closing bracket at level zero.
    '{ROW_BYTE, "a",    1'b1, 1'b1, '{24'd1, 16'd0, 1'b0}},
    '{ROW_BYTE, 8'h00,  1'b1, 1'b1, '{24'd1, 16'd0, 1'b0}},
    '{ROW_BYTE, 8'hFF,  1'b1, 1'b1, '{24'd1, 16'd0, 1'b0}},
    '{ROW_BYTE, "(",    1'b1, 1'b1, '{24'd1, 16'd1, 1'b0}},
    '{ROW_BYTE, ")",    1'b1, 1'b1, '{24'd1, 16'd0, 1'b0}},
    // An opener, then a closer still being gathered when the source ends.
    '{ROW_BYTE, "i",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "f",    1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h0A,  1'b0, 1'b0, '0},
    '{ROW_BYTE, "e",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "n",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "d",    1'b1, 1'b1, '{24'd2, 16'd1, 1'b0}},
    // A closer at keyword level zero does nothing.
    '{ROW_BYTE, "e",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "n",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "d",    1'b1, 1'b1, '{24'd1, 16'd0, 1'b0}},
    // A comment line hides its keyword.
    '{ROW_BYTE, "#",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "i",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "f",    1'b1, 1'b1, '{24'd2, 16'd0, 1'b0}},
    // Mixed-case opener followed by a bracket; left to the predictor.
    '{ROW_BYTE, "D",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "o",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "(",    1'b1, 1'b0, '0},
    // Indentation mode: a tab gives one level.
    '{ROW_MODE, 8'h01,  1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h09,  1'b0, 1'b0, '0},
    '{ROW_BYTE, "x",    1'b1, 1'b1, '{24'd1, 16'd1, 1'b0}},
    // The mode changes between two lines of one source; the second line is
    // judged as keywords.
    '{ROW_BYTE, "a",    1'b0, 1'b0, '0},
    '{ROW_BYTE, 8'h0A,  1'b0, 1'b0, '0},
    '{ROW_MODE, 8'h00,  1'b0, 1'b0, '0},
    '{ROW_BYTE, "d",    1'b0, 1'b0, '0},
    '{ROW_BYTE, "o",    1'b1, 1'b1, '{24'd2, 16'd1, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  source_token_depth_scanner #(
    .INDENT_STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scan predictor. It mirrors the block's state and is stepped once for every
  // source beat that the block accepts.
  // ---------------------------------------------------------------------------
  bit               mode_q;
  bit               in_word;
  bit [15:0]        bracket_lvl;
  bit [23:0]        token_tally;
  bit [15:0]        deepest_lvl;
  bit [15:0]        block_lvl;
  stdc_pkg::phase_t phase;
  bit [15:0]        lead_cols;
  bit [7:0]         word_buf [stdc_pkg::WORD_CAP];
  int               word_len;
  bit [15:0]        indent_stack [STACK_DEPTH];
  int               indent_used;
  bit               stack_overflowed;

  // Closers come first, openers after them.
  string block_words [12] = '{"end", "endif", "enddo", "endselect", "if", "for", "while",
                              "do", "select", "function", "program", "subroutine"};
  string punct_chars = "()[]{}+-*/=;,.:<>@$&|^~?";
  string comment_marks = "#%!";

  // Results still owed by the block, oldest first.
  scan_result_t pending_results [$];

  function automatic void clear_scan();
    in_word = 1'b0;
    bracket_lvl = '0;
    token_tally = '0;
    deepest_lvl = '0;
    block_lvl = '0;
    phase = stdc_pkg::PHASE_LEAD;
    lead_cols = '0;
    word_len = 0;
    indent_used = 0;
    stack_overflowed = 1'b0;
  endfunction

  function automatic void lift_deepest(int level);
    if (level > deepest_lvl) deepest_lvl = (level > LEVEL_CEIL) ? LEVEL_CEIL : level[15:0];
  endfunction

  function automatic bit is_letter(bit [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_word_char(bit [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic bit is_blank(bit [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // The first word of a line is compared once it is complete; a word longer
  // than the buffer can match nothing.
  function automatic void judge_word();
    string w;
    w = "";
    if (word_len > stdc_pkg::WORD_CAP) return;
    for (int i = 0; i < word_len; i++) w = $sformatf("%s%c", w, word_buf[i]);
    foreach (block_words[k]) begin
      if (w == block_words[k]) begin
        if (k < CLOSER_COUNT) begin
          if (block_lvl != 0) block_lvl--;
        end else begin
          if (block_lvl != LEVEL_CEIL) block_lvl++;
          lift_deepest(block_lvl);
        end
        return;
      end
    end
  endfunction

  // Pop every level wider than this line, then push the line's width if it is
  // wider than what remains. A push onto a full stack only raises the flag.
  function automatic void settle_indent();
    bit [15:0] top;
    while (indent_used > 0 && lead_cols < indent_stack[indent_used - 1]) indent_used--;
    top = (indent_used > 0) ? indent_stack[indent_used - 1] : 16'd0;
    if (lead_cols > top) begin
      if (indent_used < STACK_DEPTH) begin
        indent_stack[indent_used] = lead_cols;
        indent_used++;
      end else begin
        stack_overflowed = 1'b1;
      end
    end
    lift_deepest(indent_used);
  endfunction

  function automatic void take_word_char(bit [7:0] c);
    if (is_letter(c)) begin
      if (word_len < stdc_pkg::WORD_CAP) word_buf[word_len] = c | 8'h20;
      if (word_len <= stdc_pkg::WORD_CAP) word_len++;
    end else begin
      judge_word();
      phase = stdc_pkg::PHASE_REST;
    end
  endfunction

  // Returns 1 when the byte ends the source, with the result in res.
  function automatic bit scan_byte(bit [7:0] c, bit fin, output scan_result_t res);
    bit wc;
    int cols;
    wc = is_word_char(c);
    res = '0;
    if ((wc && !in_word) || (!wc && !is_blank(c))) begin
      if (token_tally != TOKEN_CEIL) token_tally++;
    end
    in_word = wc;

    if (c == "(" || c == "[" || c == "{") begin
      if (bracket_lvl != LEVEL_CEIL) bracket_lvl++;
      lift_deepest(bracket_lvl);
    end else if ((c == ")" || c == "]" || c == "}") && bracket_lvl != 0) begin
      bracket_lvl--;
    end

    if (c == 8'h0A) begin
      if (phase == stdc_pkg::PHASE_WORD) judge_word();
      phase = stdc_pkg::PHASE_LEAD;
      lead_cols = '0;
      word_len = 0;
    end else if (phase == stdc_pkg::PHASE_LEAD) begin
      if (c == " " || c == 8'h09) begin
        cols = lead_cols + ((c == 8'h09) ? TAB_COLUMNS : 1);
        lead_cols = (cols > LEVEL_CEIL) ? LEVEL_CEIL : cols[15:0];
      end else if (c == "#" || c == "%" || c == "!") begin
        phase = stdc_pkg::PHASE_REST;
      end else if (mode_q == MODE_INDENT) begin
        settle_indent();
        phase = stdc_pkg::PHASE_REST;
      end else begin
        phase = stdc_pkg::PHASE_WORD;
        take_word_char(c);
      end
    end else if (phase == stdc_pkg::PHASE_WORD) begin
      take_word_char(c);
    end

    if (!fin) return 1'b0;
    if (phase == stdc_pkg::PHASE_WORD) judge_word();
    res.tokens = token_tally;
    res.depth = deepest_lvl;
    res.overflow = stack_overflowed;
    clear_scan();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls on m_tready, and the comparison of every result
  // beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  bit idling = 1'b1;
  int stall_left = 0;
  int errors = 0;
  int cycles = 0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    scan_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.tokens = m_tdata[23:0];
      got.depth = m_tdata[39:24];
      got.overflow = m_tdata[40];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got tokens %0d depth %0d flag %0d",
                 $time, got.tokens, got.depth, got.overflow);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.tokens != want.tokens) begin
          $display("%0t: token_count expected %0d, got %0d", $time, want.tokens, got.tokens);
          errors++;
        end
        if (got.depth != want.depth) begin
          $display("%0t: max_depth expected %0d, got %0d", $time, want.depth, got.depth);
          errors++;
        end
        if (got.overflow != want.overflow) begin
          $display("%0t: indent_overflow expected %0d, got %0d", $time, want.overflow,
                   got.overflow);
          errors++;
        end
      end
    end
  end

  // Watchdog: the run is abandoned well beyond the slowest correct run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Source side. Every task starts and ends just after a falling edge, so the
  // inputs only ever change at a falling edge, away from the sampling edge.
  // ---------------------------------------------------------------------------
  bit sender_idles = 1'b1;
  bit [7:0] text_q [$];

  // Appends one byte to the text being gathered.
  function automatic void put_byte(bit [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Offer one beat, wait for it to be taken, then update the predictor. A typed
  // row replaces the predicted result with the one written in the table.
  task automatic send_byte(bit [7:0] b, bit fin, bit typed, scan_result_t table_result);
    scan_result_t predicted;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = fin;
    do @(posedge clk); while (!s_tready);
    if (scan_byte(b, fin, predicted))
      pending_results.insert(pending_results.size(), typed ? table_result : predicted);
    @(negedge clk);
  endtask

  // Hold the source back until every owed result has been taken and the block
  // has had time to settle.
  task automatic drain();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A register write always follows a drain, so the block is idle when it lands.
  task automatic set_mode(bit m);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_INDENT_MODE;
    pwdata = {31'd0, m};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    mode_q = m;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Sends the gathered text as one source. Now and then, while the sender is
  // allowed to pause, the mode is changed between two lines, which the block
  // must pick up at the next line.
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
      if (sender_idles && text_q[i] == 8'h0A && i != text_q.size() - 1 &&
          $urandom_range(0, 29) == 0)
        set_mode(1'($urandom_range(0, 1)));
    end
    text_q.delete();
  endtask

  function automatic bit [7:0] pick_letter();
    bit [7:0] c;
    c = 8'($urandom_range(0, 25)) + "a";
    if ($urandom_range(0, 3) == 0) c = c & 8'hDF;
    return c;
  endfunction

  // Keywords go in with random capitals, since the block folds case.
  function automatic void add_word(string w);
    bit [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      put_byte(($urandom_range(0, 3) == 0) ? (c & 8'hDF) : c);
    end
  endfunction

  function automatic void add_ident(int n);
    put_byte(pick_letter());
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: put_byte(8'($urandom_range(0, 9)) + "0");
        1: put_byte("_");
        default: put_byte(pick_letter());
      endcase
    end
  endfunction

  // One line of plausible source: optional indentation, a first word that is
  // often a keyword, then a tail of mixed tokens.
  function automatic void add_line();
    int n;
    n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    repeat (n) put_byte(($urandom_range(0, 2) == 0) ? 8'h09 : " ");
    case ($urandom_range(0, 9))
      0: put_byte(comment_marks[$urandom_range(0, 2)]);
      1: ;
      2, 3, 4, 5: begin
        add_word(block_words[$urandom_range(0, 11)]);
        case ($urandom_range(0, 5))
          // A trailing letter spoils the match; a digit ends the word.
          0: put_byte(pick_letter());
          1: put_byte(8'($urandom_range(0, 9)) + "0");
          default: ;
        endcase
      end
      6: add_ident($urandom_range(9, 13));
      7: put_byte(punct_chars[$urandom_range(0, 5)]);
      default: add_ident($urandom_range(1, 5));
    endcase
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 4))
        0: put_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : " ");
        1: add_ident($urandom_range(1, 4));
        default: put_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
      endcase
    end
    put_byte(8'h0A);
  endfunction

  // Lines of strictly rising width, one column per line; more rungs than the
  // stack holds makes it overflow in indentation mode.
  function automatic void add_ladder(int rungs);
    for (int w = 1; w <= rungs; w++) begin
      repeat (w / TAB_COLUMNS) put_byte(8'h09);
      repeat (w % TAB_COLUMNS) put_byte(" ");
      put_byte("x");
      put_byte(8'h0A);
    end
  endfunction

  // Builds one random source; a quarter are cut short so that the last byte
  // can fall inside a word or inside the indentation.
  function automatic void add_random_source();
    int r;
    int keep;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
    end else if (r < 16) begin
      add_ladder($urandom_range(2, STACK_DEPTH + 4));
      repeat ($urandom_range(1, 3)) add_line();
    end else begin
      repeat ($urandom_range(1, 4)) add_line();
    end
    if ($urandom_range(0, 3) == 0) begin
      keep = $urandom_range(1, text_q.size());
      text_q = text_q[0:keep - 1];
    end
  endfunction

  initial begin
    int random_sent;
    int sources_sent;
    int calm_sent;

    mode_q = MODE_KEYWORD;
    clear_scan();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table.
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_MODE) begin
        set_mode(DIRECTED_ROWS[i].data[0]);
      end else begin
        send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                  DIRECTED_ROWS[i].want);
      end
    end

    // A long source in indentation mode, sent without gaps: lines of rising
    // width push the indentation stack past full.
    sender_idles = 1'b0;
    set_mode(MODE_INDENT);
    add_ladder(STACK_DEPTH + 3);
    repeat (4) add_line();
    send_text();
    set_mode(MODE_KEYWORD);

    // Random sources, with idling switched on and off in stretches and the odd
    // mode change, which always waits for the block to drain first.
    random_sent = 0;
    sources_sent = 0;
    while (random_sent < RANDOM_BYTES || sources_sent < RANDOM_SOURCES) begin
      sender_idles = ($urandom_range(0, 4) != 0);
      idling = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 6) == 0) set_mode(1'($urandom_range(0, 1)));
      add_random_source();
      random_sent += text_q.size();
      sources_sent++;
      send_text();
    end

    // Closing stretch at full rate on both sides.
    sender_idles = 1'b0;
    idling = 1'b0;
    calm_sent = 0;
    while (calm_sent < CALM_BYTES) begin
      add_random_source();
      calm_sent += text_q.size();
      send_text();
    end

    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### source_token_depth_scanner.f
+incdir+sv
sv/stdc_pkg.sv
sv/stdc_indent_cell.sv
sv/stdc_indent_stack.sv
sv/stdc_word_match.sv
sv/source_token_depth_scanner.sv
sv/stdc_checker.sv
tb/source_token_depth_scanner_test.sv
